// ===== sv/lpf_pkg.sv =====
// Package with the transaction types shared by the longest previous factor block.
package lpf_pkg;

  localparam int FIELD_W = 6;

  typedef struct packed {
    logic [FIELD_W-1:0] suffix_start;
    logic [FIELD_W-1:0] common_prefix;
    logic               last;
  } sa_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] factor_length;
    logic               final_res;
  } lpf_item_t;

endpackage

// ===== sv/lpf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/longest_previous_factor_top.sv =====
// Top level of the longest previous factor builder (stack method over SA and LCP).
//
// Input channel sa_*: one transaction per rank of the suffix array, carrying the
// suffix start and its LCP with the previous rank; last marks the final rank.
// Output channel lpf_*: one transaction per text position popped from the stack,
// giving that position and its longest previous factor length; a final rank and
// its flush emit at most MAX_TEXT - 1 of them. After the final rank the stack is
// flushed, and position 0 with length 0 closes the array with final_res set.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. The block works on one rank at a time and holds sa_stall high
// until that rank is fully processed.
// Per rank: the transaction is taken, then each stack pop emits and reads the next
// stack entry from RAM in S_CHECK and loads it as the new top in S_FETCH (the pop
// that empties the stack skips S_FETCH), and then the rank is pushed. A final rank
// adds its flush pops and the closing transaction. Each suffix is pushed and popped
// at most once, and the pace is set by the registered read of the stack RAM that
// each pop waits on.
// A stalled output holds its transaction; pops that need to emit wait for it.
// Synchronous reset empties the stack and starts a new array; RAM contents are
// not cleared, since only entries below the stack count are read.
module longest_previous_factor_top
  import lpf_pkg::*;
#(
  parameter int MAX_TEXT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sa_valid,
  output logic      sa_stall,
  input  sa_item_t  sa_data,
  output logic      lpf_valid,
  input  logic      lpf_stall,
  output lpf_item_t lpf_data
);

  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int EW = 2 * FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;       // entries on the stack
  logic [CW-1:0]      ecount;      // results emitted for the current rank
  logic               first_seen;
  logic               flushing;
  logic               last_item;
  logic [FIELD_W-1:0] cur_start;
  logic [FIELD_W-1:0] run;
  logic [FIELD_W-1:0] top_start;   // cached copy of the top stack entry
  logic [FIELD_W-1:0] top_len;

  logic               out_free;
  logic               pop;
  logic               emit_ok;
  logic               pop_go;
  logic               done;
  logic               push;
  logic               final_go;
  logic               emit_go;
  logic [CW-1:0]      limit;
  logic [CW-1:0]      cnt_m2;
  logic               ram_rd_en;
  logic [EW-1:0]      ram_rd_data;
  logic [FIELD_W-1:0] pop_len;
  logic [FIELD_W-1:0] run_min;

  always_comb begin
    out_free  = !lpf_valid || !lpf_stall;
    pop       = (state == S_CHECK) && (count != '0) && (cur_start < top_start);
    limit     = last_item ? CW'(MAX_TEXT - 1) : CW'(MAX_TEXT);
    emit_ok   = ecount < limit;
    pop_go    = pop && (out_free || !emit_ok);
    done      = (state == S_CHECK) && !pop;
    push      = done && !flushing && (count < CW'(MAX_TEXT));
    final_go  = done && flushing && out_free;
    emit_go   = (pop_go && emit_ok) || final_go;
    cnt_m2    = count - CW'(2);
    ram_rd_en = pop_go && (count > CW'(1));
    pop_len   = (top_len > run) ? top_len : run;
    run_min   = (top_len < run) ? top_len : run;
  end

  assign sa_stall = (state != S_IDLE);

  lpf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TEXT)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count[AW-1:0]),
    .wr_data ({run, cur_start}),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      first_seen <= 1'b0;
      flushing   <= 1'b0;
      lpf_valid  <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (emit_go) begin
        lpf_valid <= 1'b1;
      end else if (!lpf_stall) begin
        lpf_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sa_valid) begin
            cur_start <= sa_data.suffix_start;
            run       <= first_seen ? sa_data.common_prefix : '0;
            last_item <= sa_data.last;
            ecount    <= '0;
            flushing  <= 1'b0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pop_go) begin
            if (emit_ok) begin
              lpf_data.position      <= top_start;
              lpf_data.factor_length <= pop_len;
              lpf_data.final_res     <= 1'b0;
              ecount                 <= ecount + CW'(1);
            end
            run   <= run_min;
            count <= count - CW'(1);
            state <= (count > CW'(1)) ? S_FETCH : S_CHECK;
          end else if (done && !flushing) begin
            if (push) begin
              count     <= count + CW'(1);
              top_start <= cur_start;
              top_len   <= run;
            end
            if (last_item) begin
              // The flush behaves as a sentinel rank with start 0 and LCP 0.
              flushing  <= 1'b1;
              cur_start <= '0;
              run       <= '0;
            end else begin
              first_seen <= 1'b1;
              state      <= S_IDLE;
            end
          end else if (final_go) begin
            // Entries with start 0 are dropped without results.
            lpf_data.position      <= '0;
            lpf_data.factor_length <= '0;
            lpf_data.final_res     <= 1'b1;
            count                  <= '0;
            first_seen             <= 1'b0;
            flushing               <= 1'b0;
            state                  <= S_IDLE;
          end
        end
        S_FETCH: begin
          top_len   <= ram_rd_data[EW-1:FIELD_W];
          top_start <= ram_rd_data[FIELD_W-1:0];
          state     <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TEXT))
    else $error("stack count exceeds depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !first_seen |-> (count == '0))
    else $error("stack not empty between arrays");

  a_idle_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && first_seen |-> (count != '0))
    else $error("stack empty inside an array");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop_go |=> (count == $past(count) - CW'(1)))
    else $error("pop did not shrink the stack");

  a_final_zero: assert property (@(posedge clk) disable iff (rst)
    final_go |=> lpf_valid && lpf_data.final_res && (count == '0))
    else $error("closing transaction malformed");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the longest previous factor builder.
`timescale 1ns / 1ps

module testbench
  import lpf_pkg::*;
();

  localparam int STACK_DEPTH = 64;

  // Tracks the block's stack of pending suffixes and queues the factor lengths
  // that every accepted rank must produce, in order.
  class factor_scoreboard;
    lpf_item_t pending_lpf[$];
    logic [FIELD_W-1:0] carried_len[STACK_DEPTH];
    logic [FIELD_W-1:0] stacked_start[STACK_DEPTH];
    int unsigned depth;
    bit array_open;
    int unsigned emitted;
    int errors;

    function new();
      depth = 0;
      array_open = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_lpf.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void queue_factor(logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] len,
                               logic fin, int unsigned cap);
      lpf_item_t r;
      if (emitted >= cap) return;
      r.position = pos;
      r.factor_length = len;
      r.final_res = fin;
      pending_lpf = {pending_lpf, r};
      emitted++;
    endfunction

    // Pops every entry whose start is above the given start; each pop yields
    // the larger of the carried length and the running LCP, and the running
    // LCP shrinks to the smaller of the two.
    function logic [FIELD_W-1:0] pop_above(logic [FIELD_W-1:0] start,
                                           logic [FIELD_W-1:0] run,
                                           int unsigned cap);
      logic [FIELD_W-1:0] top_len;
      logic [FIELD_W-1:0] top_pos;
      while (depth > 0 && start < stacked_start[depth-1]) begin
        top_len = carried_len[depth-1];
        top_pos = stacked_start[depth-1];
        queue_factor(top_pos, (top_len > run) ? top_len : run, 1'b0, cap);
        if (top_len < run) run = top_len;
        depth--;
      end
      return run;
    endfunction

    function void predict_factors(sa_item_t it);
      int unsigned cap;
      logic [FIELD_W-1:0] run;
      // On the final rank one slot is always kept free for the closing result.
      cap = it.last ? STACK_DEPTH - 1 : STACK_DEPTH;
      emitted = 0;
      run = array_open ? it.common_prefix : '0;
      run = pop_above(it.suffix_start, run, cap);
      if (depth < STACK_DEPTH) begin
        carried_len[depth] = run;
        stacked_start[depth] = it.suffix_start;
        depth++;
      end
      array_open = 1'b1;
      if (it.last) begin
        void'(pop_above('0, '0, cap));
        queue_factor('0, '0, 1'b1, STACK_DEPTH);
        depth = 0;
        array_open = 1'b0;
      end
    endfunction

    task check_result(lpf_item_t got);
      lpf_item_t want;
      if (pending_lpf.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos %0d len %0d final %0b",
                                  got.position, got.factor_length, got.final_res));
        return;
      end
      want = pending_lpf.pop_front();
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, wanted %0d",
                                  got.position, want.position));
      if (got.factor_length !== want.factor_length)
        report_mismatch($sformatf("factor_length %0d at position %0d, wanted %0d",
                                  got.factor_length, want.position, want.factor_length));
      if (got.final_res !== want.final_res)
        report_mismatch($sformatf("final_res %0b at position %0d, wanted %0b",
                                  got.final_res, want.position, want.final_res));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sa_valid = 1'b0;
  logic      sa_stall;
  sa_item_t  sa_data = '0;
  logic      lpf_valid;
  logic      lpf_stall = 1'b0;
  lpf_item_t lpf_data;

  factor_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int ranks_sent = 0;
  int txt[STACK_DEPTH];

  longest_previous_factor_top #(
    .MAX_TEXT(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sa_valid (sa_valid),
    .sa_stall (sa_stall),
    .sa_data  (sa_data),
    .lpf_valid(lpf_valid),
    .lpf_stall(lpf_stall),
    .lpf_data (lpf_data)
  );

  always #1 clk = ~clk;

  // Both channels are observed at the clock edge, where the sampled values are
  // the ones from before the edge. The input transaction is predicted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (sa_valid && !sa_stall) sb.predict_factors(sa_data);
      if (lpf_valid && !lpf_stall) sb.check_result(lpf_data);
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        lpf_stall <= 1'b1;
        rx_hold--;
      end else begin
        lpf_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  function automatic sa_item_t rank_of(int start, int cp, bit fin);
    sa_item_t it;
    it.suffix_start = start[FIELD_W-1:0];
    it.common_prefix = cp[FIELD_W-1:0];
    it.last = fin;
    return it;
  endfunction

  task automatic send_rank(input sa_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      sa_valid <= 1'b0;
      @(posedge clk);
    end
    sa_valid <= 1'b1;
    sa_data <= it;
    @(posedge clk);
    while (sa_stall) @(posedge clk);
    ranks_sent++;
  endtask

  // The sender stops offering until every expected result has come out.
  task automatic wait_results_done();
    sa_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Lexicographic order of two suffixes of txt; a proper prefix sorts first.
  function automatic bit suffix_less(int a, int b, int n);
    while (a < n && b < n && txt[a] == txt[b]) begin
      a++;
      b++;
    end
    return (a == n) ? (b != n) : (b != n && txt[a] < txt[b]);
  endfunction

  function automatic int common_len(int a, int b, int n);
    int k;
    k = 0;
    while (a + k < n && b + k < n && txt[a+k] == txt[b+k]) k++;
    return k;
  endfunction

  // A well-formed array: random text, its suffix array and LCP array. The LCP
  // of the first rank is random, since the block must ignore it.
  task automatic send_text_array(int n, int alpha);
    int order[STACK_DEPTH];
    int key;
    int j;
    int cp;
    for (int i = 0; i < n; i++) begin
      txt[i] = $urandom_range(alpha - 1);
      order[i] = i;
    end
    for (int i = 1; i < n; i++) begin
      key = order[i];
      j = i - 1;
      while (j >= 0 && suffix_less(key, order[j], n)) begin
        order[j+1] = order[j];
        j--;
      end
      order[j+1] = key;
    end
    for (int i = 0; i < n; i++) begin
      cp = (i == 0) ? $urandom_range(63) : common_len(order[i-1], order[i], n);
      send_rank(rank_of(order[i], cp, i == n - 1));
    end
  endtask

  // Arbitrary fields; last may fall anywhere or be missing, so arrays also
  // run into each other.
  task automatic send_noise_array();
    int len;
    len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++)
      send_rank(rank_of($urandom_range(63), $urandom_range(63),
                        (i == len - 1) ? ($urandom_range(4) != 0) : ($urandom_range(9) == 0)));
  endtask

  // Sixty-five ranks with non-decreasing starts above zero never pop, so the
  // stack fills and the last push is dropped. The closing rank then pops all
  // sixty-four entries, more than fit before the closing result.
  task automatic send_full_stack_array();
    int starts[STACK_DEPTH+1];
    int key;
    int j;
    for (int i = 0; i <= STACK_DEPTH; i++) starts[i] = $urandom_range(63, 1);
    for (int i = 1; i <= STACK_DEPTH; i++) begin
      key = starts[i];
      j = i - 1;
      while (j >= 0 && starts[j] > key) begin
        starts[j+1] = starts[j];
        j--;
      end
      starts[j+1] = key;
    end
    for (int i = 0; i <= STACK_DEPTH; i++)
      send_rank(rank_of(starts[i], $urandom_range(63), 1'b0));
    send_rank(rank_of($urandom_range(1) ? 0 : $urandom_range(63), $urandom_range(63), 1'b1));
  endtask

  task automatic run_random(int target);
    while (ranks_sent < target) begin
      if ($urandom_range(99) < 72) send_text_array($urandom_range(12, 1), $urandom_range(4, 1));
      else send_noise_array();
    end
  endtask

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles rarely, receiver often.
    tx_idle_pct = 14;
    rx_idle_pct = 62;

    // A lone rank at position 0 yields only the closing result; its LCP is ignored.
    send_rank(rank_of(0, 63, 1'b1));
    // A lone rank elsewhere is flushed at once.
    send_rank(rank_of(63, 0, 1'b1));
    // Pops by a smaller start, no pop on an equal start, a top start of 63.
    send_rank(rank_of(5, 63, 1'b0));
    send_rank(rank_of(3, 2, 1'b0));
    send_rank(rank_of(3, 0, 1'b0));
    send_rank(rank_of(63, 63, 1'b0));
    send_rank(rank_of(0, 0, 1'b1));
    // Entries at position 0 are dropped silently by the flush.
    send_rank(rank_of(0, 0, 1'b0));
    send_rank(rank_of(0, 5, 1'b0));
    send_rank(rank_of(10, 7, 1'b1));
    // Position 0 never arrives, but the closing result still does.
    send_rank(rank_of(7, 0, 1'b0));
    send_rank(rank_of(2, 1, 1'b1));
    // A real array of a short text.
    send_text_array(6, 2);
    wait_results_done();

    // The receiver holds off for a long stretch while ranks keep coming.
    rx_hold = 300;
    run_random(60);
    wait_results_done();

    // Phase two: sender idles often, receiver rarely.
    tx_idle_pct = 62;
    rx_idle_pct = 14;
    send_full_stack_array();
    run_random(145);
    wait_results_done();

    // Phase three: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_text_array($urandom_range(64, 32), $urandom_range(2, 1));
    run_random(215);
    // Close any array that noise left open.
    send_rank(rank_of(0, 0, 1'b1));
    wait_results_done();
    repeat (30) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lpf_pkg.sv
sv/lpf_ram.sv
sv/longest_previous_factor_top.sv
sim/testbench.sv
